// ----- hdl/u16u8_pkg.sv -----
// Shared types, constants and the code point encoder of the UTF-16 to UTF-8 transcoder.
package u16u8_pkg;

    // Field widths.
    localparam int UNIT_W   = 16;
    localparam int BYTE_W   = 8;
    localparam int CP_W     = 21;
    localparam int HBITS_W  = 10;

    // Surrogate prefixes on the top six bits of a code unit.
    localparam logic [5:0] SURR_HIGH_TAG = 6'b110110;
    localparam logic [5:0] SURR_LOW_TAG  = 6'b110111;

    // High surrogate bits plus this offset, shifted by ten, give the plane base.
    localparam logic [10:0] SUPP_PLANE_OFS = 11'h040;

    // Bytes of one item: a held surrogate (three) and a code point (up to three then).
    localparam int MAX_BYTES = 6;
    localparam int BIDX_W    = $clog2(MAX_BYTES);
    localparam int HELD_BYTES = 3;

    // Queue between the front and the back.
    localparam int QDEPTH = 2;
    localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // Lead byte marks and masks.
    localparam logic [7:0] LEAD2_MARK = 8'hc0;
    localparam logic [7:0] LEAD3_MARK = 8'he0;
    localparam logic [7:0] LEAD4_MARK = 8'hf0;
    localparam logic [7:0] CONT_MARK  = 8'h80;

    // Range limits of the UTF-8 lengths.
    localparam logic [CP_W-1:0] LIM1 = 21'h00007f;
    localparam logic [CP_W-1:0] LIM2 = 21'h0007ff;
    localparam logic [CP_W-1:0] LIM3 = 21'h00ffff;

    // One classified item handed from the front to the back.
    typedef struct packed {
        logic               held_valid;
        logic [HBITS_W-1:0] held_bits;
        logic               cp_valid;
        logic [CP_W-1:0]    cp;
        logic               eos;
    } job_t;

    // Encoded form of one code point.
    typedef struct packed {
        logic [3:0][BYTE_W-1:0] bytes;
        logic [2:0]             len;
    } enc_t;

    // Encodes one code point as one to four UTF-8 bytes, first byte in slot 0.
    function automatic enc_t enc_cp(input logic [CP_W-1:0] cp);
        enc_t e;
        e.bytes = '0;
        if (cp <= LIM1) begin
            e.bytes[0] = cp[7:0];
            e.len      = 3'd1;
        end else if (cp <= LIM2) begin
            e.bytes[0] = LEAD2_MARK | {3'b000, cp[10:6]};
            e.bytes[1] = CONT_MARK | {2'b00, cp[5:0]};
            e.len      = 3'd2;
        end else if (cp <= LIM3) begin
            e.bytes[0] = LEAD3_MARK | {4'b0000, cp[15:12]};
            e.bytes[1] = CONT_MARK | {2'b00, cp[11:6]};
            e.bytes[2] = CONT_MARK | {2'b00, cp[5:0]};
            e.len      = 3'd3;
        end else begin
            e.bytes[0] = LEAD4_MARK | {5'b00000, cp[20:18]};
            e.bytes[1] = CONT_MARK | {2'b00, cp[17:12]};
            e.bytes[2] = CONT_MARK | {2'b00, cp[11:6]};
            e.bytes[3] = CONT_MARK | {2'b00, cp[5:0]};
            e.len      = 3'd4;
        end
        return e;
    endfunction

endpackage

// ----- hdl/utf16_to_utf8_transcoder_unit.sv -----
// Top level of the UTF-16 to UTF-8 transcoder.
//
//  Channel | Direction | tdata           | tlast          | tuser
//  s_      | in        | [15:0] code_unit| last_unit      | -
//  m_      | out       | [7:0] out_byte  | end_of_string  | last_of_item
//
// A code unit is accepted in any cycle the two-entry job queue has room; its job is
// registered in the queue and then in the back. While m_tready is high the back
// sends one byte per cycle, single-byte units are sustained at one per cycle, and a
// unit of several bytes holds the back until all are sent; the front stalls once the
// queue fills. A held high surrogate produces no bytes until the next unit arrives.
// Reset is synchronous on aresetn low and clears the held surrogate and the queue.
module utf16_to_utf8_transcoder_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] code_unit
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] out_byte
    output logic        m_tuser,   // [0] last_of_item
    output logic        m_tlast
);

    logic            q_ready;
    logic            push_valid;
    u16u8_pkg::job_t push_job;
    logic            head_valid;
    u16u8_pkg::job_t head_job;
    logic            pop;

    // Front part: surrogate pairing and classification.
    u16u8_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .code_unit  (s_tdata),
        .last_unit  (s_tlast),
        .q_ready    (q_ready),
        .push_valid (push_valid),
        .push_job   (push_job)
    );

    // Job queue.
    u16u8_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push_valid),
        .push_job   (push_job),
        .not_full   (q_ready),
        .head_valid (head_valid),
        .head_job   (head_job),
        .pop        (pop)
    );

    // Back part: byte expansion and output.
    u16u8_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .head_valid    (head_valid),
        .head_job      (head_job),
        .pop           (pop),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .out_byte      (m_tdata),
        .last_of_item  (m_tuser),
        .end_of_string (m_tlast)
    );

endmodule

// ----- hdl/u16u8_front.sv -----
// Front part: accepts code units, pairs surrogates and classifies each item into a job.
module u16u8_front (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [u16u8_pkg::UNIT_W-1:0]   code_unit,
    input  logic                           last_unit,
    input  logic                           q_ready,
    output logic                           push_valid,
    output u16u8_pkg::job_t                push_job
);

    logic                               pending_valid_reg;
    logic                               pending_valid_next;
    logic [u16u8_pkg::HBITS_W-1:0]      pending_bits_reg;
    logic [u16u8_pkg::HBITS_W-1:0]      pending_bits_next;
    logic                               accept;
    logic                               is_high;
    logic                               is_low;
    logic                               hold_new;
    logic [10:0]                        plane_bits;

    assign s_tready = q_ready;
    assign accept   = s_tvalid && s_tready;
    assign is_high  = (code_unit[15:10] == u16u8_pkg::SURR_HIGH_TAG);
    assign is_low   = (code_unit[15:10] == u16u8_pkg::SURR_LOW_TAG);
    assign hold_new = is_high && !last_unit;
    assign plane_bits = {1'b0, pending_bits_reg} + u16u8_pkg::SUPP_PLANE_OFS;

    // Classify the incoming unit against the held surrogate.
    always_comb begin
        push_job            = '0;
        push_job.eos        = last_unit;
        push_job.held_bits  = pending_bits_reg;
        pending_valid_next  = pending_valid_reg;
        pending_bits_next   = pending_bits_reg;
        if (accept) begin
            if (pending_valid_reg && is_low) begin
                // A surrogate pair makes one supplementary code point.
                push_job.cp_valid  = 1'b1;
                push_job.cp        = {plane_bits, code_unit[9:0]};
                pending_valid_next = 1'b0;
            end else begin
                // A lone held surrogate goes out first as three bytes.
                push_job.held_valid = pending_valid_reg;
                if (hold_new) begin
                    pending_valid_next = 1'b1;
                    pending_bits_next  = code_unit[9:0];
                end else begin
                    push_job.cp_valid  = 1'b1;
                    push_job.cp        = {5'b00000, code_unit};
                    pending_valid_next = 1'b0;
                end
            end
        end
    end

    assign push_valid = accept && (push_job.held_valid || push_job.cp_valid);

    // Held surrogate state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_valid_reg <= 1'b0;
            pending_bits_reg  <= '0;
        end else begin
            pending_valid_reg <= pending_valid_next;
            pending_bits_reg  <= pending_bits_next;
        end
    end

endmodule

// ----- hdl/u16u8_queue.sv -----
// Short job queue between the front and the back parts.
module u16u8_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  u16u8_pkg::job_t push_job,
    output logic            not_full,
    output logic            head_valid,
    output u16u8_pkg::job_t head_job,
    input  logic            pop
);

    u16u8_pkg::job_t                    entries_reg [u16u8_pkg::QDEPTH];
    logic [u16u8_pkg::QPTR_W-1:0]       wr_ptr_reg;
    logic [u16u8_pkg::QPTR_W-1:0]       wr_ptr_next;
    logic [u16u8_pkg::QPTR_W-1:0]       rd_ptr_reg;
    logic [u16u8_pkg::QPTR_W-1:0]       rd_ptr_next;
    logic [u16u8_pkg::QCNT_W-1:0]       count_reg;
    logic [u16u8_pkg::QCNT_W-1:0]       count_next;
    logic                               do_pop;

    assign not_full   = (count_reg != u16u8_pkg::QCNT_W'(u16u8_pkg::QDEPTH));
    assign head_valid = (count_reg != '0);
    assign head_job   = entries_reg[rd_ptr_reg];
    assign do_pop     = pop && head_valid;

    // Pointer and fill count updates.
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            if (wr_ptr_reg == u16u8_pkg::QPTR_W'(u16u8_pkg::QDEPTH - 1)) begin
                wr_ptr_next = '0;
            end else begin
                wr_ptr_next = wr_ptr_reg + 1'b1;
            end
        end
        if (do_pop) begin
            if (rd_ptr_reg == u16u8_pkg::QPTR_W'(u16u8_pkg::QDEPTH - 1)) begin
                rd_ptr_next = '0;
            end else begin
                rd_ptr_next = rd_ptr_reg + 1'b1;
            end
        end
        if (push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (!push && do_pop) begin
            count_next = count_reg - 1'b1;
        end
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge aclk) begin
        if (push) begin
            entries_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

// ----- hdl/u16u8_back.sv -----
// Back part: expands one job into its UTF-8 bytes and sends them one byte per cycle while m_tready is high.
module u16u8_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          head_valid,
    input  u16u8_pkg::job_t               head_job,
    output logic                          pop,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [u16u8_pkg::BYTE_W-1:0]  out_byte,
    output logic                          last_of_item,
    output logic                          end_of_string
);

    logic [u16u8_pkg::BYTE_W-1:0]   bytes_reg [u16u8_pkg::MAX_BYTES];
    logic [u16u8_pkg::BYTE_W-1:0]   bytes_next [u16u8_pkg::MAX_BYTES];
    logic [u16u8_pkg::BIDX_W-1:0]   idx_reg;
    logic [u16u8_pkg::BIDX_W-1:0]   idx_next;
    logic [u16u8_pkg::BIDX_W-1:0]   final_reg;
    logic [u16u8_pkg::BIDX_W-1:0]   final_next;
    logic                           busy_reg;
    logic                           busy_next;
    logic                           eos_reg;
    logic                           eos_next;
    logic                           at_final;
    logic                           done;
    logic                           load;
    u16u8_pkg::enc_t                held_enc;
    u16u8_pkg::enc_t                cp_enc;
    logic [2:0]                     count;

    assign held_enc = u16u8_pkg::enc_cp({5'b00000, u16u8_pkg::SURR_HIGH_TAG,
                                         head_job.held_bits});
    assign cp_enc   = u16u8_pkg::enc_cp(head_job.cp);

    assign at_final = (idx_reg == final_reg);
    assign done     = !busy_reg || (m_tready && at_final);
    assign load     = done && head_valid;
    assign pop      = load;

    // Lay out the bytes of the job at the queue head.
    always_comb begin
        for (int i = 0; i < u16u8_pkg::MAX_BYTES; i++) begin
            bytes_next[i] = '0;
        end
        if (head_job.held_valid) begin
            for (int i = 0; i < u16u8_pkg::HELD_BYTES; i++) begin
                bytes_next[i] = held_enc.bytes[i];
                bytes_next[i + u16u8_pkg::HELD_BYTES] = cp_enc.bytes[i];
            end
            count = 3'd3 + (head_job.cp_valid ? cp_enc.len : 3'd0);
        end else begin
            for (int i = 0; i < 4; i++) begin
                bytes_next[i] = cp_enc.bytes[i];
            end
            count = cp_enc.len;
        end
        final_next = u16u8_pkg::BIDX_W'(count - 3'd1);
        eos_next   = head_job.eos;
    end

    // Byte sequencer.
    always_comb begin
        busy_next = busy_reg;
        idx_next  = idx_reg;
        if (load) begin
            busy_next = 1'b1;
            idx_next  = '0;
        end else if (done) begin
            busy_next = 1'b0;
        end else if (m_tready) begin
            idx_next = idx_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
        end
    end

    // Job payload, taken when a new job is loaded.
    always_ff @(posedge aclk) begin
        if (load) begin
            for (int i = 0; i < u16u8_pkg::MAX_BYTES; i++) begin
                bytes_reg[i] <= bytes_next[i];
            end
            final_reg <= final_next;
            eos_reg   <= eos_next;
        end
    end

    assign m_tvalid      = busy_reg;
    assign out_byte      = bytes_reg[idx_reg];
    assign last_of_item  = at_final;
    assign end_of_string = at_final && eos_reg;

endmodule

// ----- bench/tb_utf16_to_utf8_transcoder_unit.sv -----
// Self-checking bench for the UTF-16 to UTF-8 transcoder: directed and random strings.
`timescale 1ns / 1ps

// One UTF-8 byte as the block should send it.
typedef struct {
    logic [7:0] value;
    logic       item_end;
    logic       str_end;
} utf8_byte_t;

// Tracks the held surrogate and the bytes still owed by the block.
class utf8_scoreboard;
    bit         surr_held;
    logic [9:0] surr_bits;
    logic [7:0] unit_bytes[$];
    utf8_byte_t owed_bytes[$];
    int         errors;

    function new();
        surr_held = 0;
        surr_bits = '0;
        errors    = 0;
    endfunction

    // Appends one byte to the bytes of the current item.
    function void add_byte(logic [7:0] value);
        unit_bytes.insert(unit_bytes.size(), value);
    endfunction

    // Appends the UTF-8 form of one code point to the bytes of the current item.
    function void encode_point(logic [20:0] cp);
        if (cp <= 21'h7f) begin
            add_byte(cp[7:0]);
        end else if (cp <= 21'h7ff) begin
            add_byte(8'hc0 | {3'b000, cp[10:6]});
            add_byte(8'h80 | {2'b00, cp[5:0]});
        end else if (cp <= 21'hffff) begin
            add_byte(8'he0 | {4'b0000, cp[15:12]});
            add_byte(8'h80 | {2'b00, cp[11:6]});
            add_byte(8'h80 | {2'b00, cp[5:0]});
        end else begin
            add_byte(8'hf0 | {5'b00000, cp[20:18]});
            add_byte(8'h80 | {2'b00, cp[17:12]});
            add_byte(8'h80 | {2'b00, cp[11:6]});
            add_byte(8'h80 | {2'b00, cp[5:0]});
        end
    endfunction

    // Works out the bytes that one accepted code unit causes.
    function void note_unit(logic [15:0] unit, logic last);
        bit         is_high;
        bit         is_low;
        bit         paired;
        utf8_byte_t b;
        is_high = (unit[15:10] == 6'b110110);
        is_low  = (unit[15:10] == 6'b110111);
        paired  = 0;
        unit_bytes.delete();
        // A held high surrogate either pairs up or goes out alone.
        if (surr_held) begin
            if (is_low) begin
                encode_point(21'h10000 + {1'b0, surr_bits, unit[9:0]});
                paired = 1;
            end else begin
                encode_point({5'd0, 6'b110110, surr_bits});
            end
            surr_held = 0;
            surr_bits = '0;
        end
        if (!paired) begin
            if (is_high && !last) begin
                surr_held = 1;
                surr_bits = unit[9:0];
            end else begin
                encode_point({5'd0, unit});
            end
        end
        foreach (unit_bytes[i]) begin
            b.value    = unit_bytes[i];
            b.item_end = (i == unit_bytes.size() - 1);
            b.str_end  = (i == unit_bytes.size() - 1) && last;
            owed_bytes.insert(owed_bytes.size(), b);
        end
    endfunction

    // Compares one sent byte with the oldest byte owed.
    function void check_byte(logic [7:0] value, logic item_end, logic str_end);
        utf8_byte_t want;
        if (owed_bytes.size() == 0) begin
            $display("%0t: unexpected byte: expected none, actual %h item_end %b str_end %b",
                     $time, value, item_end, str_end);
            errors++;
            return;
        end
        want = owed_bytes.pop_front();
        if (value !== want.value) begin
            $display("%0t: out_byte: expected %h, actual %h", $time, want.value, value);
            errors++;
        end
        if (item_end !== want.item_end) begin
            $display("%0t: last_of_item: expected %b, actual %b",
                     $time, want.item_end, item_end);
            errors++;
        end
        if (str_end !== want.str_end) begin
            $display("%0t: end_of_string: expected %b, actual %b",
                     $time, want.str_end, str_end);
            errors++;
        end
    endfunction
endclass

module tb_utf16_to_utf8_transcoder_unit;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int HOLD_CYCLES    = 80;
    localparam int RANDOM_UNITS   = 175;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;
    logic        m_tuser;
    logic        m_tlast;

    utf8_scoreboard sb = new();
    bit  send_idle;
    bit  recv_idle;
    bit  hold_req;
    int  quiet_cycles;
    int  units_sent;

    utf16_to_utf8_transcoder_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // Clock with an 8 ns period.
    initial aclk = 1'b0;
    always #4 aclk = ~aclk;

    // Note accepted units and check sent bytes at each rising edge.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready)
                sb.note_unit(s_tdata, s_tlast);
            if (m_tvalid && m_tready)
                sb.check_byte(m_tdata, m_tuser, m_tlast);
        end
    end

    // Watchdog: too many cycles in a row with no handshake on either side.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("utf16_to_utf8_transcoder_unit: mismatch");
            $finish;
        end
    end

    // Receiver: random stalls, stretches without them, and one long hold-off.
    initial begin
        int stall;
        m_tready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            stall = recv_idle ? $urandom_range(0, 5) : 0;
            if (hold_req) begin
                stall    = HOLD_CYCLES;
                hold_req = 0;
            end
            if (stall > 0) begin
                @(negedge aclk);
                m_tready <= 1'b0;
                repeat (stall - 1) @(negedge aclk);
            end
            @(negedge aclk);
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    // Offers one code unit, after a random gap when send_idle is set, and waits until it is taken.
    task automatic send_unit(input logic [15:0] unit, input logic last);
        int gap;
        gap = send_idle ? $urandom_range(0, 5) : 0;
        if (gap > 0) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= unit;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        units_sent++;
    endtask

    // Lowers valid and waits until every owed byte has been sent.
    task automatic drain();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (sb.owed_bytes.size() != 0) @(posedge aclk);
    endtask

    // Sends one random string of one to eight characters.
    task automatic send_random_string();
        int          len;
        int          kind;
        logic [15:0] u;
        len = $urandom_range(1, 8);
        for (int i = 0; i < len; i++) begin
            kind = $urandom_range(0, 9);
            case (kind)
                0, 1: begin
                    send_unit(16'($urandom_range(16'h0000, 16'h007f)), i == len - 1);
                end
                2: begin
                    send_unit(16'($urandom_range(16'h0080, 16'h07ff)), i == len - 1);
                end
                3: begin
                    // Three-byte character outside the surrogate range.
                    u = 16'($urandom_range(16'h0800, 16'hf7ff));
                    if (u >= 16'hd800)
                        u = u + 16'h0800;
                    send_unit(u, i == len - 1);
                end
                4, 5, 6: begin
                    // Well-formed surrogate pair with random content.
                    send_unit({6'b110110, 10'($urandom)}, 1'b0);
                    send_unit({6'b110111, 10'($urandom)}, i == len - 1);
                end
                7: begin
                    send_unit({6'b110110, 10'($urandom)}, i == len - 1);
                end
                8: begin
                    send_unit({6'b110111, 10'($urandom)}, i == len - 1);
                end
                default: begin
                    send_unit(16'($urandom), i == len - 1);
                end
            endcase
        end
    endtask

    // Main sequence: reset, directed cases, pressure, random strings, end check.
    initial begin
        aresetn      = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tlast      = 1'b0;
        send_idle    = 1;
        recv_idle    = 1;
        hold_req     = 0;
        quiet_cycles = 0;
        units_sent   = 0;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Range limits of each UTF-8 length.
        send_unit(16'h0000, 1'b0);
        send_unit(16'h007f, 1'b0);
        send_unit(16'h0080, 1'b0);
        send_unit(16'h07ff, 1'b0);
        send_unit(16'h0800, 1'b1);
        send_unit(16'hffff, 1'b0);
        // Lowest and highest supplementary code points.
        send_unit(16'hd800, 1'b0);
        send_unit(16'hdc00, 1'b0);
        send_unit(16'hdbff, 1'b0);
        send_unit(16'hdfff, 1'b1);
        // High surrogate that ends the string goes out alone.
        send_unit(16'hdbff, 1'b1);
        // Lone low surrogates.
        send_unit(16'hdc00, 1'b0);
        send_unit(16'hdfff, 1'b0);
        // Held surrogate followed by an ordinary character.
        send_unit(16'hd800, 1'b0);
        send_unit(16'h0041, 1'b0);
        // Held surrogate followed by another high surrogate, which then pairs.
        send_unit(16'hdabc, 1'b0);
        send_unit(16'hd9ab, 1'b0);
        send_unit(16'hdd55, 1'b1);
        // Held surrogate followed by a high surrogate that ends the string.
        send_unit(16'hd800, 1'b0);
        send_unit(16'hdbff, 1'b1);
        // Just outside the surrogate range, and a one-unit string.
        send_unit(16'hd7ff, 1'b0);
        send_unit(16'he000, 1'b1);
        send_unit(16'h0001, 1'b1);
        drain();

        // Long receiver hold-off while units keep coming back to back.
        send_idle = 0;
        hold_req  = 1;
        for (int i = 0; i < 12; i++)
            send_unit(16'h0800 + 16'(i * 16'h0111), i == 11);
        // Sender pauses until the block has sent everything.
        drain();

        // Random strings, idling switched on and off per string.
        units_sent = 0;
        while (units_sent < RANDOM_UNITS) begin
            send_idle = ($urandom_range(0, 3) != 0);
            recv_idle = ($urandom_range(0, 3) != 0);
            send_random_string();
        end
        drain();
        repeat (20) @(posedge aclk);

        if (sb.errors == 0 && sb.owed_bytes.size() == 0)
            $display("utf16_to_utf8_transcoder_unit: match");
        else
            $display("utf16_to_utf8_transcoder_unit: mismatch");
        $finish;
    end
endmodule
